// ===== hw/rtl/owbm_pkg.sv =====
// Shared types and constants for the single-wire bus master.
// Used by owbm_regs and onewire_bus_master; depends on nothing else.
package owbm_pkg;

	localparam int REG_W     = 10;
	localparam int NUM_REGS  = 7;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

	localparam logic [REG_W-1:0] REG_DEFAULTS [NUM_REGS] = '{
		10'd480, 10'd60, 10'd420, 10'd1, 10'd60, 10'd14, 10'd45
	};

	localparam logic [2:0] OP_RESET      = 3'd0;
	localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
	localparam logic [2:0] OP_READ_BIT   = 3'd2;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd3;
	localparam logic [2:0] OP_READ_BYTE  = 3'd4;

	localparam int         BIT_CNT_W     = 4;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_SLOT_START,
		PH_WRITE_HOLD,
		PH_READ_WAIT,
		PH_READ_TAIL
	} phase_t;

endpackage

// ===== hw/rtl/onewire_bus_master.sv =====
// Single-wire bus master: tick-driven slot sequencer with configurable timing.
// Depends on owbm_pkg and owbm_regs.
//
// Every input word is one microsecond tick. It carries the sampled line level
// and, when command_valid is set, a command: bus reset with presence detect,
// write bit, read bit, write byte or read byte (bytes least significant bit first).
// Every accepted word yields exactly one output word holding the line pull-down,
// the busy flag, the done pulse and the read value (presence bit, bit or byte).
// Commands that arrive while a command is running, including on its completion
// tick, are ignored, as are undefined opcodes.
// The output word for a tick is registered at the edge that accepts the tick.
// Throughput is one tick per clock while the receiver keeps up; the sequencer
// state updates once per accepted word in a single pass of logic.
// The output register is a single stage; while the receiver stalls, s_tready is
// low and the tick is held upstream. A new word is taken in the same cycle that
// the pending output is taken.
// Reset clears the sequencer to idle, empties the output register and loads the
// default slot timings. The timing registers may be rewritten while idle.
module onewire_bus_master #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,  // command_data[7:0], line_level[8]
	input  logic [3:0]                     s_tuser,  // command_valid[0], opcode[3:1]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,  // drive_low, busy_res, done_res,
	                                                 // read_value[10:3]
	input  logic                           cfg_we,
	input  logic [owbm_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [owbm_pkg::REG_W-1:0]     cfg_wdata
);
	import owbm_pkg::*;

	logic                   accept;
	logic                   cmd_valid;
	logic [2:0]             opcode;
	logic [7:0]             command_data;
	logic                   line_level;

	phase_t                 phase_q, ph_e, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_e, tick_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_e, bit_d;
	logic [7:0]             shift_q, shift_e, shift_d;
	logic [2:0]             op_q, op_e;
	logic                   samp_q, samp_e, samp_d;
	logic                   start;

	logic [COUNT_WIDTH-1:0] phase_len;
	logic [COUNT_WIDTH:0]   tick_inc;
	logic                   phase_end;
	logic                   cmd_end;

	logic                   drive_d, busy_d;
	logic [7:0]             value_d;

	logic                   m_tvalid_q, drive_q, busy_q, done_q;
	logic [7:0]             value_q;

	assign cmd_valid    = s_tuser[0];
	assign opcode       = s_tuser[3:1];
	assign command_data = s_tdata[7:0];
	assign line_level   = s_tdata[8];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	owbm_regs #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.phase     (ph_e),
		.phase_len (phase_len)
	);

	always_comb begin
		start = (phase_q == PH_IDLE) && cmd_valid &&
			(opcode inside {OP_RESET, OP_WRITE_BIT, OP_READ_BIT, OP_WRITE_BYTE, OP_READ_BYTE});
		if (start) begin
			ph_e    = (opcode == OP_RESET) ? PH_RST_LOW : PH_SLOT_START;
			tick_e  = '0;
			bit_e   = '0;
			shift_e = command_data;
			op_e    = opcode;
			samp_e  = 1'b0;
		end else begin
			ph_e    = phase_q;
			tick_e  = tick_q;
			bit_e   = bit_cnt_q;
			shift_e = shift_q;
			op_e    = op_q;
			samp_e  = samp_q;
		end
	end

	assign tick_inc  = {1'b0, tick_e} + {{COUNT_WIDTH{1'b0}}, 1'b1};
	assign phase_end = (tick_inc >= {1'b0, phase_len});

	// Next state of the sequencer.
	always_comb begin
		phase_d = ph_e;
		tick_d  = tick_e;
		bit_d   = bit_e;
		shift_d = shift_e;
		samp_d  = samp_e;
		cmd_end = 1'b0;
		if (ph_e != PH_IDLE) begin
			if ((ph_e == PH_RST_TAIL || ph_e == PH_READ_TAIL) && tick_e == '0) begin
				samp_d = line_level;
			end
			tick_d = tick_inc[COUNT_WIDTH-1:0];
			if (phase_end) begin
				tick_d = '0;
				case (ph_e)
					PH_RST_LOW:  phase_d = PH_RST_WAIT;
					PH_RST_WAIT: phase_d = PH_RST_TAIL;
					PH_RST_TAIL: begin
						cmd_end = 1'b1;
						phase_d = PH_IDLE;
					end
					PH_SLOT_START: begin
						phase_d = (op_e == OP_WRITE_BIT || op_e == OP_WRITE_BYTE) ?
							PH_WRITE_HOLD : PH_READ_WAIT;
					end
					PH_WRITE_HOLD: begin
						shift_d = {1'b0, shift_e[7:1]};
						bit_d   = bit_e + 1'b1;
						if (op_e == OP_WRITE_BIT || bit_d >= BITS_PER_BYTE) begin
							cmd_end = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_SLOT_START;
						end
					end
					PH_READ_WAIT: phase_d = PH_READ_TAIL;
					PH_READ_TAIL: begin
						if (op_e == OP_READ_BIT) begin
							cmd_end = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							shift_d = {samp_d, shift_e[7:1]};
							bit_d   = bit_e + 1'b1;
							if (bit_d >= BITS_PER_BYTE) begin
								cmd_end = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_SLOT_START;
							end
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Line drive and result of this tick.
	always_comb begin
		busy_d  = (ph_e != PH_IDLE);
		value_d = '0;
		case (ph_e)
			PH_RST_LOW, PH_SLOT_START: drive_d = 1'b1;
			PH_WRITE_HOLD:             drive_d = !shift_e[0];
			default:                   drive_d = 1'b0;
		endcase
		if (cmd_end) begin
			if (ph_e == PH_RST_TAIL) begin
				value_d = {7'd0, samp_d};
			end else if (ph_e == PH_READ_TAIL) begin
				value_d = (op_e == OP_READ_BIT) ? {7'd0, samp_d} : shift_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			op_q      <= OP_RESET;
			samp_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_cnt_q <= bit_d;
			shift_q   <= shift_d;
			op_q      <= op_e;
			samp_q    <= samp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drive_q <= drive_d;
			busy_q  <= busy_d;
			done_q  <= cmd_end;
			value_q <= value_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, value_q, done_q, busy_q, drive_q};

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_IDLE && !cmd_valid) |=> (phase_q == PH_IDLE))
		else $error("sequencer left idle without a command");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_end) |=> (phase_q == PH_IDLE))
		else $error("command completed but sequencer not idle");

	a_bits_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (bit_cnt_q < BITS_PER_BYTE))
		else $error("bit counter ran past a byte during a command");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && drive_d) |=> (busy_q && m_tvalid_q))
		else $error("line driven low while no command in progress");

	a_tick_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ph_e != PH_IDLE && phase_d == ph_e && !start) |=> (tick_q != '0))
		else $error("tick counter did not advance within a phase");

endmodule

// ===== hw/rtl/owbm_regs.sv =====
// Timing register file of the single-wire bus master and the phase length lookup.
// Depends on owbm_pkg.
module owbm_regs #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [owbm_pkg::REG_IDX_W-1:0]    cfg_addr,
	input  logic [owbm_pkg::REG_W-1:0]        cfg_wdata,
	input  owbm_pkg::phase_t                  phase,
	output logic [COUNT_WIDTH-1:0]            phase_len
);
	import owbm_pkg::*;

	localparam int CMP_W = ((COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W) + 1;
	localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [REG_W-1:0] regs_q [NUM_REGS];
	logic [REG_W-1:0] raw_len;
	logic [CMP_W-1:0] ext_len;
	logic [CMP_W-1:0] clamped_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_DEFAULTS[i];
			end
		end else if (cfg_we && (cfg_addr <= REG_READ_TAIL)) begin
			regs_q[cfg_addr] <= cfg_wdata;
		end
	end

	always_comb begin
		case (phase)
			PH_RST_LOW:    raw_len = regs_q[REG_RESET_LOW];
			PH_RST_WAIT:   raw_len = regs_q[REG_PRESENCE_WAIT];
			PH_RST_TAIL:   raw_len = regs_q[REG_RESET_TAIL];
			PH_SLOT_START: raw_len = regs_q[REG_SLOT_START];
			PH_WRITE_HOLD: raw_len = regs_q[REG_WRITE_HOLD];
			PH_READ_WAIT:  raw_len = regs_q[REG_READ_SAMPLE];
			default:       raw_len = regs_q[REG_READ_TAIL];
		endcase
		ext_len = CMP_W'(raw_len);
		if (ext_len == '0) begin
			clamped_len = CMP_W'(1);
		end else if (ext_len > LEN_MAX) begin
			clamped_len = LEN_MAX;
		end else begin
			clamped_len = ext_len;
		end
		phase_len = clamped_len[COUNT_WIDTH-1:0];
	end

endmodule
